// ===== rtl/olmct_pkg.sv =====
// package: shared constants and types for the open-list min-cost table
`default_nettype none
package olmct_pkg;
   localparam int CAPACITY_DEF    = 64;
   localparam int COORD_WIDTH_DEF = 10;
   localparam int AGE_W           = 16;

   typedef enum logic [1:0] {
      CMD_INSERT  = 2'd0,
      CMD_FIND    = 2'd1,
      CMD_EXTRACT = 2'd2,
      CMD_NOP     = 2'd3
   } cmd_type;
endpackage
`default_nettype wire

// ===== rtl/olmct_ram.sv =====
// generic single-port ram with registered read
`default_nettype none
module olmct_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule
`default_nettype wire

// ===== rtl/olmct_front.sv =====
// front end: accepts command words into a two-entry queue
`default_nettype none
module olmct_front #(
   parameter int CW = 10
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_stall,
   input  wire logic [1:0]    req_command,
   input  wire logic [CW-1:0] req_pos_x,
   input  wire logic [CW-1:0] req_pos_y,
   input  wire logic [31:0]   req_entry_cost,
   input  wire logic [31:0]   req_entry_payload,
   output logic               q_valid,
   input  wire logic          q_pop,
   output olmct_pkg::cmd_type q_cmd,
   output logic [CW-1:0]      q_x,
   output logic [CW-1:0]      q_y,
   output logic [31:0]        q_cost,
   output logic [31:0]        q_payload
);
   localparam int EW = 2 + 2*CW + 64;
   logic [EW-1:0] buf_ff [2];
   logic [1:0]    cnt_ff, cnt_in;
   logic          rd_ff, wr_ff;
   logic          push, pop;

   assign req_stall = cnt_ff[1];
   assign push = req_valid && !req_stall;
   assign pop  = q_pop && q_valid;
   assign q_valid = cnt_ff != 2'd0;
   assign q_cmd = olmct_pkg::cmd_type'(buf_ff[rd_ff][EW-1 -: 2]);
   assign q_x = buf_ff[rd_ff][2*CW+63 -: CW];
   assign q_y = buf_ff[rd_ff][CW+63 -: CW];
   assign q_cost = buf_ff[rd_ff][63:32];
   assign q_payload = buf_ff[rd_ff][31:0];
   assign cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         rd_ff <= 1'b0;
         wr_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) wr_ff <= ~wr_ff;
         if (pop) rd_ff <= ~rd_ff;
      end
      if (push) begin
         buf_ff[wr_ff] <= {req_command, req_pos_x, req_pos_y, req_entry_cost,
                           req_entry_payload};
      end
   end
endmodule
`default_nettype wire

// ===== rtl/olmct_back.sv =====
// back end: carries out insert, find and extract; find, extract and the insert renumber pass scan slot memory
`default_nettype none
module olmct_back #(
   parameter int CAPACITY = 64,
   parameter int CW = 10
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          q_valid,
   output logic               q_pop,
   input  wire olmct_pkg::cmd_type q_cmd,
   input  wire logic [CW-1:0] q_x,
   input  wire logic [CW-1:0] q_y,
   input  wire logic [31:0]   q_cost,
   input  wire logic [31:0]   q_payload,
   output logic               rsp_valid,
   input  wire logic          rsp_stall,
   output logic               rsp_hit,
   output logic               rsp_full_flag,
   output logic [9:0]         rsp_out_x,
   output logic [9:0]         rsp_out_y,
   output logic [31:0]        rsp_out_cost,
   output logic [31:0]        rsp_out_payload,
   output logic [6:0]         rsp_entry_count
);
   localparam int AW = $clog2(CAPACITY);
   localparam int CNTW = $clog2(CAPACITY + 1);
   localparam int AGW = olmct_pkg::AGE_W;
   localparam int DW = 2*CW + 64 + AGW;
   localparam logic [AGW-1:0] STAMP_TOP = '1;

   typedef enum logic [3:0] {
      S_IDLE, S_SCAN, S_LAST, S_FETCH, S_DONE, S_RENUM, S_RLAST, S_OUT, S_RSTART
   } state_type;

   state_type     state_ff;
   logic [CAPACITY-1:0] valid_ff;
   logic [CNTW-1:0] held_ff;
   logic [AGW-1:0]  stamp_ff;
   logic [AW-1:0]   addr_ff, best_ff, free_ff;
   logic            found_ff, free_found_ff;
   logic [31:0]     best_cost_ff;
   logic [AGW-1:0]  best_age_ff;
   logic [AGW-1:0]  rank_ff;
   // renumber pass: repeatedly pick the oldest not yet renumbered
   logic [CAPACITY-1:0] done_ff;
   logic            wr_en;
   logic [AW-1:0]   ram_addr;
   logic [DW-1:0]   wr_data, rd_data;
   logic [AW-1:0]   scan_idx_ff;
   logic            rd_ok_ff;
   logic            start;

   logic [CW-1:0]  rd_x, rd_y;
   logic [31:0]    rd_cost, rd_pay;
   logic [AGW-1:0] rd_age;
   assign {rd_x, rd_y, rd_cost, rd_pay, rd_age} = rd_data;

   olmct_ram #(.WIDTH(DW), .DEPTH(CAPACITY)) u_ram (
      .clock(clock), .wr_en(wr_en), .addr(ram_addr),
      .wr_data(wr_data), .rd_data(rd_data)
   );

   logic last_addr;
   assign last_addr = addr_ff == AW'(CAPACITY - 1);
   // the word stays at the queue head until its result is written
   assign start = state_ff == S_IDLE && q_valid && !rsp_valid;
   assign q_pop = state_ff == S_DONE;

   logic better;
   always_comb begin
      better = 1'b0;
      if (rd_ok_ff && valid_ff[scan_idx_ff]) begin
         unique case (q_cmd)
            olmct_pkg::CMD_FIND:
               better = rd_x == q_x && rd_y == q_y &&
                        (!found_ff || rd_age > best_age_ff);
            olmct_pkg::CMD_EXTRACT:
               better = !found_ff || rd_cost < best_cost_ff ||
                        (rd_cost == best_cost_ff && rd_age > best_age_ff);
            default: better = 1'b0;
         endcase
      end
   end

   // renumber candidate: oldest valid entry not yet done
   logic rbetter;
   assign rbetter = rd_ok_ff && valid_ff[scan_idx_ff] && !done_ff[scan_idx_ff] &&
                    (!found_ff || rd_age < best_age_ff);

   always_comb begin
      wr_en = 1'b0;
      ram_addr = addr_ff;
      wr_data = {q_x, q_y, q_cost, q_payload, stamp_ff};
      if (state_ff == S_DONE && q_cmd == olmct_pkg::CMD_INSERT && free_found_ff) begin
         wr_en = 1'b1;
         ram_addr = free_ff;
      end else if (state_ff == S_IDLE || state_ff == S_RSTART) begin
         // slot 0 is read ahead so a scan can begin next cycle
         ram_addr = '0;
      end else if (state_ff == S_FETCH || state_ff == S_LAST || state_ff == S_RLAST) begin
         ram_addr = best_ff;
      end else if (state_ff == S_OUT) begin
         ram_addr = best_ff;
         wr_en = 1'b1;
         wr_data = {rd_x, rd_y, rd_cost, rd_pay, rank_ff};
      end
   end

   logic [CNTW-1:0] held_next;
   always_comb begin
      held_next = held_ff;
      if (q_cmd == olmct_pkg::CMD_INSERT && free_found_ff) begin
         held_next = held_ff + 1'b1;
      end else if (q_cmd == olmct_pkg::CMD_EXTRACT && found_ff) begin
         held_next = held_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= '0;
         held_ff <= '0;
         stamp_ff <= '0;
         rsp_valid <= 1'b0;
         rd_ok_ff <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) rsp_valid <= 1'b0;
         rd_ok_ff <= 1'b0;
         scan_idx_ff <= addr_ff;
         unique case (state_ff)
            S_IDLE: begin
               if (start) begin
                  addr_ff <= '0;
                  found_ff <= 1'b0;
                  free_found_ff <= 1'b0;
                  if (q_cmd == olmct_pkg::CMD_INSERT) begin
                     state_ff <= S_DONE;
                     free_found_ff <= ~&valid_ff;
                     free_ff <= '0;
                     for (int i = CAPACITY - 1; i >= 0; i--) begin
                        if (!valid_ff[i]) free_ff <= AW'(i);
                     end
                     if (~&valid_ff && stamp_ff == STAMP_TOP) begin
                        state_ff <= S_RENUM;
                        done_ff <= '0;
                        rank_ff <= '0;
                        rd_ok_ff <= 1'b1;
                        addr_ff <= AW'(1);
                        scan_idx_ff <= '0;
                     end
                  end else if (q_cmd == olmct_pkg::CMD_NOP) begin
                     state_ff <= S_DONE;
                  end else begin
                     state_ff <= S_SCAN;
                     rd_ok_ff <= 1'b1;
                     addr_ff <= AW'(1);
                     scan_idx_ff <= '0;
                  end
               end
            end
            S_SCAN: begin
               if (better) begin
                  found_ff <= 1'b1;
                  best_ff <= scan_idx_ff;
                  best_cost_ff <= rd_cost;
                  best_age_ff <= rd_age;
               end
               if (scan_idx_ff == AW'(CAPACITY - 1)) begin
                  state_ff <= S_FETCH;
               end else begin
                  rd_ok_ff <= 1'b1;
                  if (!last_addr) addr_ff <= addr_ff + 1'b1;
               end
            end
            S_FETCH: state_ff <= S_LAST;
            S_LAST: state_ff <= S_DONE;
            S_RENUM: begin
               if (rbetter) begin
                  found_ff <= 1'b1;
                  best_ff <= scan_idx_ff;
                  best_age_ff <= rd_age;
               end
               if (scan_idx_ff == AW'(CAPACITY - 1)) begin
                  state_ff <= S_RLAST;
               end else begin
                  rd_ok_ff <= 1'b1;
                  if (!last_addr) addr_ff <= addr_ff + 1'b1;
               end
            end
            S_RLAST: begin
               // chosen entry is read here and rewritten with its rank next cycle
               if (found_ff) begin
                  state_ff <= S_OUT;
               end else begin
                  stamp_ff <= AGW'(held_ff);
                  state_ff <= S_DONE;
               end
            end
            S_OUT: begin
               done_ff[best_ff] <= 1'b1;
               rank_ff <= rank_ff + 1'b1;
               found_ff <= 1'b0;
               state_ff <= S_RSTART;
            end
            S_RSTART: begin
               state_ff <= S_RENUM;
               rd_ok_ff <= 1'b1;
               addr_ff <= AW'(1);
               scan_idx_ff <= '0;
            end
            S_DONE: begin
               rsp_valid <= 1'b1;
               rsp_hit <= 1'b0;
               rsp_full_flag <= 1'b0;
               rsp_out_x <= '0;
               rsp_out_y <= '0;
               rsp_out_cost <= '0;
               rsp_out_payload <= '0;
               unique case (q_cmd)
                  olmct_pkg::CMD_INSERT: begin
                     if (free_found_ff) begin
                        valid_ff[free_ff] <= 1'b1;
                        stamp_ff <= stamp_ff + 1'b1;
                        rsp_hit <= 1'b1;
                     end else begin
                        rsp_full_flag <= 1'b1;
                     end
                  end
                  olmct_pkg::CMD_FIND, olmct_pkg::CMD_EXTRACT: begin
                     if (found_ff) begin
                        rsp_hit <= 1'b1;
                        rsp_out_x <= 10'(rd_x);
                        rsp_out_y <= 10'(rd_y);
                        rsp_out_cost <= rd_cost;
                        rsp_out_payload <= rd_pay;
                        if (q_cmd == olmct_pkg::CMD_EXTRACT) begin
                           valid_ff[best_ff] <= 1'b0;
                        end
                     end
                  end
                  default: ;
               endcase
               held_ff <= held_next;
               rsp_entry_count <= 7'(held_next);
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

// ===== rtl/open_list_min_cost_table.sv =====
// top level of the open-list min-cost table
// Holds up to CAPACITY entries in one single-port memory. An insert takes a free
// slot from the valid flags and gives its result without a scan; find and
// extract scan every slot through the memory read port. When the insert stamp
// runs out, one insert first renumbers ages, one full scan per held entry and a
// last scan that finds none. A command starts only once the previous result has
// been taken. A two-word queue takes commands while a scan runs.
`default_nettype none
module open_list_min_cost_table #(
   parameter int CAPACITY    = olmct_pkg::CAPACITY_DEF,
   parameter int COORD_WIDTH = olmct_pkg::COORD_WIDTH_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic [1:0]             req_command,
   input  wire logic [COORD_WIDTH-1:0] req_pos_x,
   input  wire logic [COORD_WIDTH-1:0] req_pos_y,
   input  wire logic [31:0]            req_entry_cost,
   input  wire logic [31:0]            req_entry_payload,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic                        rsp_hit,
   output logic                        rsp_full_flag,
   output logic [9:0]                  rsp_out_x,
   output logic [9:0]                  rsp_out_y,
   output logic [31:0]                 rsp_out_cost,
   output logic [31:0]                 rsp_out_payload,
   output logic [6:0]                  rsp_entry_count
);
   logic q_valid, q_pop;
   olmct_pkg::cmd_type q_cmd;
   logic [COORD_WIDTH-1:0] q_x, q_y;
   logic [31:0] q_cost, q_payload;

   olmct_front #(.CW(COORD_WIDTH)) u_front (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .req_command(req_command), .req_pos_x(req_pos_x), .req_pos_y(req_pos_y),
      .req_entry_cost(req_entry_cost), .req_entry_payload(req_entry_payload),
      .q_valid(q_valid), .q_pop(q_pop), .q_cmd(q_cmd), .q_x(q_x), .q_y(q_y),
      .q_cost(q_cost), .q_payload(q_payload)
   );

   olmct_back #(.CAPACITY(CAPACITY), .CW(COORD_WIDTH)) u_back (
      .clock(clock), .reset(reset), .q_valid(q_valid), .q_pop(q_pop),
      .q_cmd(q_cmd), .q_x(q_x), .q_y(q_y), .q_cost(q_cost), .q_payload(q_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_hit(rsp_hit),
      .rsp_full_flag(rsp_full_flag), .rsp_out_x(rsp_out_x), .rsp_out_y(rsp_out_y),
      .rsp_out_cost(rsp_out_cost), .rsp_out_payload(rsp_out_payload),
      .rsp_entry_count(rsp_entry_count)
   );
endmodule
`default_nettype wire
